@@ src/bbd_pkg.sv @@
package bbd_pkg;

    // Register file layout (word index = paddr[3:2])
    localparam int          APB_ADDR_W      = 4;
    localparam logic [1:0]  REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0]  REG_SAMPLE_BITS  = 2'd2;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
    localparam logic [4:0]  SAMPLE_BITS_RST  = 5'd8;

    // Block queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Output pixel order inside a block
    localparam logic [1:0] PIX_TOP_LEFT  = 2'd0;
    localparam logic [1:0] PIX_TOP_RIGHT = 2'd1;
    localparam logic [1:0] PIX_BOT_LEFT  = 2'd2;
    localparam logic [1:0] PIX_BOT_RIGHT = 2'd3;

    // One completed 2x2 block; coordinates are those of the red sample
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green_top;
        logic [7:0]  green_bot;
        logic [7:0]  blue;
        logic [11:0] pos_x;
        logic [15:0] pos_y;
    } block_t;

endpackage

@@ src/bayer_bggr_block_demosaic_top.sv @@
// Path: front-end block register, then queue entry, then back-end output register.
// Throughput: one sample per cycle on top lines of a block row while no finished block
//   waits for the queue; on bottom lines the output port sets the pace at one pixel per
//   cycle, four per block; once the four-block queue fills, bottom-line samples wait.
// Reset: synchronous active-low aresetn clears position counters, queue and output valid;
//   the line store is not cleared and registers return to 640 x 480, 8-bit samples.
module bayer_bggr_block_demosaic_top
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] sample
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [55:0]           m_axis_tdata,   // red, green, blue, pixel_x, pixel_y, pad
    output logic                  m_axis_tlast,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [12:0] frame_width_reg;
    logic [15:0] frame_height_reg;
    logic [4:0]  sample_bits_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    logic        fq_valid, fq_ready;
    block_t      fq_block;
    logic        qb_valid, qb_ready;
    block_t      qb_block;

    logic [7:0]  out_red, out_green, out_blue;
    logic [11:0] out_x;
    logic [15:0] out_y;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            sample_bits_reg  <= SAMPLE_BITS_RST;
        end else if (cfg_wr) begin
            if (reg_idx == REG_FRAME_WIDTH) begin
                frame_width_reg <= pwdata[12:0];
            end
            if (reg_idx == REG_FRAME_HEIGHT) begin
                frame_height_reg <= pwdata[15:0];
            end
            if (reg_idx == REG_SAMPLE_BITS) begin
                sample_bits_reg <= pwdata[4:0];
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            REG_SAMPLE_BITS:  prdata = 32'(sample_bits_reg);
            default:          prdata = 32'd0;
        endcase
    end

    bbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_sample     (s_axis_tdata),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .sample_bits  (sample_bits_reg),
        .push_valid   (fq_valid),
        .push_ready   (fq_ready),
        .push_block   (fq_block)
    );

    bbd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_block (fq_block),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_block  (qb_block)
    );

    bbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_valid (qb_valid),
        .blk_ready (qb_ready),
        .blk       (qb_block),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_red     (out_red),
        .m_green   (out_green),
        .m_blue    (out_blue),
        .m_pixel_x (out_x),
        .m_pixel_y (out_y),
        .m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_y, out_x, out_blue, out_green, out_red};

endmodule

@@ src/bbd_front.sv @@
module bbd_front
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_sample,
    input  logic [12:0] frame_width,
    input  logic [15:0] frame_height,
    input  logic [4:0]  sample_bits,
    output logic        push_valid,
    input  logic        push_ready,
    output block_t      push_block
);

    localparam int          CW       = $clog2(MAX_WIDTH);
    localparam int          SDEPTH   = MAX_WIDTH / 2;
    localparam int          AW       = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam logic [16:0] MAX_W17  = 17'(MAX_WIDTH);

    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   line_reg, line_next;
    logic [7:0]    held_blue_reg;
    logic [7:0]    held_green_reg;
    logic [15:0]   rd_data_reg;
    logic          blk_valid_reg;
    logic [7:0]    blk_red_reg;
    logic [7:0]    blk_gb_reg;
    logic [11:0]   blk_x_reg;
    logic [15:0]   blk_y_reg;

    // top-line store, one word per block column: {green, blue}
    logic [15:0]   line_store_mem [SDEPTH];

    logic          accept;
    logic          is_bottom;
    logic          is_odd;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] addr;
    logic [4:0]    shamt;
    logic [15:0]   shifted;
    logic [7:0]    scaled;
    logic [16:0]   eff_w;
    logic [16:0]   col_inc;
    logic [16:0]   line_inc;
    logic          end_line;
    logic          end_frame;
    logic [31:0]   col_ext;

    assign s_ready = !blk_valid_reg || push_ready;
    assign accept  = s_valid && s_ready;

    // Scale raw sample to 8 bits
    assign shamt   = (sample_bits > 5'd8) ? (sample_bits - 5'd8) : 5'd0;
    assign shifted = s_sample >> shamt;
    assign scaled  = shifted[7:0];

    // Classify by position in the Bayer pattern
    assign is_bottom = line_reg[0];
    assign is_odd    = col_reg[0];
    assign addr      = AW'(col_reg >> 1);
    assign wr_en     = accept && !is_bottom && is_odd;
    assign rd_en     = accept && is_bottom && is_odd;
    assign col_ext   = 32'(col_reg);

    // Raster position advance
    assign eff_w     = (17'(frame_width) < MAX_W17) ? 17'(frame_width) : MAX_W17;
    assign col_inc   = 17'(col_reg) + 17'd1;
    assign line_inc  = 17'(line_reg) + 17'd1;
    assign end_line  = col_inc >= eff_w;
    assign end_frame = line_inc >= 17'(frame_height);

    always_comb begin
        col_next  = col_inc[CW-1:0];
        line_next = line_reg;
        if (end_line) begin
            col_next  = '0;
            line_next = end_frame ? 16'd0 : line_inc[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            line_reg       <= '0;
            held_green_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            line_reg <= line_next;
            if (is_bottom && !is_odd) begin
                held_green_reg <= scaled;
            end
        end
    end

    // Blue of the top line is held until its green arrives
    always_ff @(posedge aclk) begin
        if (accept && !is_bottom && !is_odd) begin
            held_blue_reg <= scaled;
        end
    end

    // Line store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store_mem[addr] <= {scaled, held_blue_reg};
        end
        if (rd_en) begin
            rd_data_reg <= line_store_mem[addr];
        end
    end

    // Completed block waits here until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_valid_reg <= 1'b0;
        end else if (rd_en) begin
            blk_valid_reg <= 1'b1;
        end else if (push_ready) begin
            blk_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            blk_red_reg <= scaled;
            blk_gb_reg  <= held_green_reg;
            blk_x_reg   <= col_ext[11:0];
            blk_y_reg   <= line_reg;
        end
    end

    assign push_valid           = blk_valid_reg;
    assign push_block.red       = blk_red_reg;
    assign push_block.green_top = rd_data_reg[15:8];
    assign push_block.green_bot = blk_gb_reg;
    assign push_block.blue      = rd_data_reg[7:0];
    assign push_block.pos_x     = blk_x_reg;
    assign push_block.pos_y     = blk_y_reg;

endmodule

@@ src/bbd_queue.sv @@
module bbd_queue
    import bbd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  block_t push_block,
    output logic   pop_valid,
    input  logic   pop_ready,
    output block_t pop_block
);

    block_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_block  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_block;
        end
    end

endmodule

@@ src/bbd_back.sv @@
module bbd_back
    import bbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        blk_valid,
    output logic        blk_ready,
    input  block_t      blk,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [11:0] m_pixel_x,
    output logic [15:0] m_pixel_y,
    output logic        m_last
);

    logic [1:0]  phase_reg;
    logic        m_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [11:0] x_reg;
    logic [15:0] y_reg;
    logic        last_reg;

    logic        load;
    logic [8:0]  g_sum;
    logic [7:0]  g_avg;
    logic [11:0] x_left;
    logic [15:0] y_up;
    logic [7:0]  green_next;
    logic [11:0] x_next;
    logic [15:0] y_next;
    logic        last_next;

    assign load      = blk_valid && (!m_valid_reg || m_ready);
    assign blk_ready = load && (phase_reg == PIX_BOT_RIGHT);

    assign g_sum  = 9'(blk.green_top) + 9'(blk.green_bot);
    assign g_avg  = g_sum[8:1];
    assign x_left = blk.pos_x - 12'd1;
    assign y_up   = blk.pos_y - 16'd1;

    // Pick this phase's pixel out of the block
    always_comb begin
        unique case (phase_reg)
            PIX_TOP_LEFT: begin
                green_next = blk.green_top;
                x_next     = x_left;
                y_next     = y_up;
                last_next  = 1'b0;
            end
            PIX_TOP_RIGHT: begin
                green_next = g_avg;
                x_next     = blk.pos_x;
                y_next     = y_up;
                last_next  = 1'b0;
            end
            PIX_BOT_LEFT: begin
                green_next = blk.green_bot;
                x_next     = x_left;
                y_next     = blk.pos_y;
                last_next  = 1'b0;
            end
            PIX_BOT_RIGHT: begin
                green_next = blk.green_bot;
                x_next     = blk.pos_x;
                y_next     = blk.pos_y;
                last_next  = 1'b1;
            end
            default: begin
                green_next = blk.green_bot;
                x_next     = blk.pos_x;
                y_next     = blk.pos_y;
                last_next  = 1'b0;
            end
        endcase
    end

    // Output register and phase counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PIX_TOP_LEFT;
            m_valid_reg <= 1'b0;
        end else if (load) begin
            phase_reg   <= phase_reg + 2'd1;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            red_reg   <= blk.red;
            green_reg <= green_next;
            blue_reg  <= blk.blue;
            x_reg     <= x_next;
            y_reg     <= y_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_red     = red_reg;
    assign m_green   = green_reg;
    assign m_blue    = blue_reg;
    assign m_pixel_x = x_reg;
    assign m_pixel_y = y_reg;
    assign m_last    = last_reg;

endmodule

@@ src/bbd_checker.sv @@
module bbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // the last pixel of a block sits at an odd column and odd line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[24] && m_axis_tdata[36])
        else $error("block end at even position");

    // a block's pixels share red and blue
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
            |-> m_axis_tdata[7:0] == $past(m_axis_tdata[7:0])
                && m_axis_tdata[23:16] == $past(m_axis_tdata[23:16]))
        else $error("color changed inside a block");

endmodule

bind bayer_bggr_block_demosaic_top bbd_checker u_bbd_checker (.*);
